// File: hw/rtl/qrss_pkg.sv
// Package: types, constants and target pose table for the recovery stand sequencer.
package qrss_pkg;

    localparam int LEG_COUNT  = 4;
    localparam int ANGLE_BITS = 16;
    localparam int TICK_BITS  = 17;
    localparam int RAMP_BITS  = 16;
    localparam int LEG_BITS   = $clog2(LEG_COUNT);

    typedef enum logic [1:0] {
        PH_FOLD  = 2'd0,
        PH_STAND = 2'd1,
        PH_ROLL  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        REG_FOLD_RAMP     = 3'd0,
        REG_FOLD_SETTLE   = 3'd1,
        REG_STANDUP_RAMP  = 3'd2,
        REG_ROLLOVER_RAMP = 3'd3,
        REG_ROLLOVER_SETTLE = 3'd4
    } cfg_reg_t;

    localparam logic [1:0] JNT_ABD  = 2'd0;
    localparam logic [1:0] JNT_HIP  = 2'd1;
    localparam logic [1:0] JNT_KNEE = 2'd2;

    localparam logic             REQ_ENTER     = 1'b0;
    localparam logic [11:0]      STAND_MIN_MM  = 12'd200;
    localparam logic [11:0]      STAND_MAX_MM  = 12'd450;
    localparam logic [11:0]      FAULT_MIN_MM  = 12'd100;

    typedef struct packed {
        logic        req_type;
        logic [11:0] body_height_mm;
        logic        upside_down;
        logic [47:0] leg0_angles;
        logic [47:0] leg1_angles;
        logic [47:0] leg2_angles;
        logic [47:0] leg3_angles;
    } req_t;

    typedef struct packed {
        logic [1:0]         leg_index;
        logic signed [15:0] abduction_setpoint;
        logic signed [15:0] hip_setpoint;
        logic signed [15:0] knee_setpoint;
        logic [1:0]         phase_now;
        logic               last;
    } res_t;

    // milliradians to Q4.12, rounding half away from zero
    function automatic int to_fixed(int milli);
        int p;
        p = milli * (1 << (ANGLE_BITS - 4));
        return (p + ((p < 0) ? -500 : 500)) / 1000;
    endfunction

    localparam logic signed [ANGLE_BITS-1:0] FOLD_ABD  = ANGLE_BITS'(to_fixed(0));
    localparam logic signed [ANGLE_BITS-1:0] FOLD_HIP  = ANGLE_BITS'(to_fixed(-1400));
    localparam logic signed [ANGLE_BITS-1:0] FOLD_KNEE = ANGLE_BITS'(to_fixed(2700));
    localparam logic signed [ANGLE_BITS-1:0] STND_ABD  = ANGLE_BITS'(to_fixed(0));
    localparam logic signed [ANGLE_BITS-1:0] STND_HIP  = ANGLE_BITS'(to_fixed(-800));
    localparam logic signed [ANGLE_BITS-1:0] STND_KNEE = ANGLE_BITS'(to_fixed(1600));
    localparam logic signed [ANGLE_BITS-1:0] ROLE_ABD  = ANGLE_BITS'(to_fixed(1500));
    localparam logic signed [ANGLE_BITS-1:0] ROLE_HIP  = ANGLE_BITS'(to_fixed(-1600));
    localparam logic signed [ANGLE_BITS-1:0] ROLO_ABD  = ANGLE_BITS'(to_fixed(1300));
    localparam logic signed [ANGLE_BITS-1:0] ROLO_HIP  = ANGLE_BITS'(to_fixed(-3100));
    localparam logic signed [ANGLE_BITS-1:0] ROLL_KNEE = ANGLE_BITS'(to_fixed(2770));

    function automatic logic signed [ANGLE_BITS-1:0] target_pose(
        phase_t p, logic odd, logic [1:0] j);
        logic signed [ANGLE_BITS-1:0] v;
        v = FOLD_ABD;
        case (p)
            PH_STAND:
            begin
                case (j)
                    JNT_ABD: v = STND_ABD;
                    JNT_HIP: v = STND_HIP;
                    default: v = STND_KNEE;
                endcase
            end
            PH_ROLL:
            begin
                case (j)
                    JNT_ABD: v = odd ? ROLO_ABD : ROLE_ABD;
                    JNT_HIP: v = odd ? ROLO_HIP : ROLE_HIP;
                    default: v = ROLL_KNEE;
                endcase
            end
            default:
            begin
                case (j)
                    JNT_ABD: v = FOLD_ABD;
                    JNT_HIP: v = FOLD_HIP;
                    default: v = FOLD_KNEE;
                endcase
            end
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/qrss_interp.sv
// Bit-serial interpolator: shift-add multiply, then restoring divide with rounding.
module qrss_interp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [qrss_pkg::ANGLE_BITS-1:0] ini,
    input  logic signed [qrss_pkg::ANGLE_BITS-1:0] fin,
    input  logic [qrss_pkg::TICK_BITS-1:0]        t,
    input  logic [qrss_pkg::RAMP_BITS-1:0]        ramp,
    output logic                                  done,
    output logic signed [qrss_pkg::ANGLE_BITS-1:0] result
);
    import qrss_pkg::*;

    localparam int DFW = ANGLE_BITS + 1;
    localparam int PW  = DFW + RAMP_BITS;
    localparam int DW  = PW + 1;
    localparam int CW  = $clog2(DW);

    typedef enum logic [3:0] {
        I_IDLE = 4'b0001,
        I_MUL  = 4'b0010,
        I_DIV  = 4'b0100,
        I_DONE = 4'b1000
    } istate_t;

    istate_t                      state_reg, state_next;
    logic [CW-1:0]                cnt_reg;
    logic                         neg_reg;
    logic                         bypass_reg;
    logic signed [ANGLE_BITS-1:0] ini_reg;
    logic signed [ANGLE_BITS-1:0] fin_reg;
    logic [RAMP_BITS-1:0]         ramp_reg;
    logic [RAMP_BITS-1:0]         mplier_reg;
    logic [PW-1:0]                mcand_reg;
    logic [PW-1:0]                prod_reg;
    logic [DW-1:0]                div_reg;
    logic [RAMP_BITS-1:0]         rem_reg;

    logic signed [DFW-1:0]        diff;
    logic [DFW-1:0]               diff_mag;
    logic [RAMP_BITS:0]           trial;
    logic [DFW-1:0]               q;
    logic [DFW-1:0]               res_wide;

    assign diff     = DFW'(fin) - DFW'(ini);
    assign diff_mag = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
    assign trial    = {rem_reg, div_reg[DW-1]} - {1'b0, ramp_reg};
    assign q        = div_reg[DFW-1:0];
    assign res_wide = neg_reg ? (DFW'(ini_reg) - q) : (DFW'(ini_reg) + q);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            I_IDLE:
            begin
                if (start)
                begin
                    if (ramp == '0 || t >= TICK_BITS'(ramp))
                        state_next = I_DONE;
                    else
                        state_next = I_MUL;
                end
            end
            I_MUL:
            begin
                if (cnt_reg == CW'(RAMP_BITS - 1))
                    state_next = I_DIV;
            end
            I_DIV:
            begin
                if (cnt_reg == CW'(DW - 1))
                    state_next = I_DONE;
            end
            I_DONE:  state_next = I_IDLE;
            default: state_next = I_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= I_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg != state_next)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            I_IDLE:
            begin
                if (start)
                begin
                    ini_reg    <= ini;
                    fin_reg    <= fin;
                    ramp_reg   <= ramp;
                    neg_reg    <= diff[DFW-1];
                    bypass_reg <= (ramp == '0) || (t >= TICK_BITS'(ramp));
                    mcand_reg  <= PW'(diff_mag);
                    mplier_reg <= t[RAMP_BITS-1:0];
                    prod_reg   <= '0;
                end
            end
            I_MUL:
            begin
                if (mplier_reg[0])
                    prod_reg <= prod_reg + mcand_reg;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                if (cnt_reg == CW'(RAMP_BITS - 1))
                begin
                    div_reg <= DW'(mplier_reg[0] ? prod_reg + mcand_reg : prod_reg)
                               + DW'(ramp_reg >> 1);
                    rem_reg <= '0;
                end
            end
            I_DIV:
            begin
                if (!trial[RAMP_BITS])
                begin
                    rem_reg <= trial[RAMP_BITS-1:0];
                    div_reg <= {div_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[RAMP_BITS-2:0], div_reg[DW-1]};
                    div_reg <= {div_reg[DW-2:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done   = (state_reg == I_DONE);
    assign result = bypass_reg ? fin_reg : res_wide[ANGLE_BITS-1:0];

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == I_IDLE)
        else $error("interp start while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("interp done held");
    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !bypass_reg) |-> div_reg[DW-1:DFW] == '0)
        else $error("interp quotient overflow");

endmodule

// File: hw/rtl/quadruped_recovery_stand_sequencer_core.sv
// Top level: phase sequencer, configuration registers, start pose and result register.
// Enter request, or a stand-up fault: taken with no results.
// Tick request: LEG_COUNT results, one leg at a time. Each joint passes through the
// bit-serial interpolator (start, multiply, divide, done), or skips to done if t >= ramp.
// Each leg then holds its result until it is taken; after the last one the sequencer
// returns to idle and takes the next request, so output stalls hold up the next tick.
// Reset: fold phase, tick count zero, registers at their defaults; start pose unset.
module quadruped_recovery_stand_sequencer_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  qrss_pkg::req_t   req,
    output logic             res_valid,
    input  logic             res_ready,
    output qrss_pkg::res_t   res,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data
);
    import qrss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_WAIT  = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    phase_t                       phase_reg;
    logic [TICK_BITS-1:0]         ticks_reg;
    logic [RAMP_BITS-1:0]         fold_ramp_reg, fold_settle_reg, stand_ramp_reg;
    logic [RAMP_BITS-1:0]         roll_ramp_reg, roll_settle_reg;
    logic [LEG_BITS-1:0]          leg_reg;
    logic [1:0]                   joint_reg;
    logic                         inv_reg;
    logic signed [ANGLE_BITS-1:0] start_pose_reg [LEG_COUNT][3];
    logic signed [ANGLE_BITS-1:0] abd_reg, hip_reg, knee_reg;

    logic [47:0]                  meas [4];
    phase_t                       cur;
    logic [RAMP_BITS-1:0]         ramp_sel;
    logic                         req_fire, res_fire, is_enter, fault, tick_end;
    logic                         fold_end, roll_end, enter_stand;
    logic [20:0]                  t_x10, r_x7;
    logic                         ip_done;
    logic signed [ANGLE_BITS-1:0] ip_result;

    assign meas[0] = req.leg0_angles;
    assign meas[1] = req.leg1_angles;
    assign meas[2] = req.leg2_angles;
    assign meas[3] = req.leg3_angles;

    assign cur = (phase_reg == PH_STAND || phase_reg == PH_ROLL) ? phase_reg : PH_FOLD;

    always_comb
    begin
        case (cur)
            PH_STAND: ramp_sel = stand_ramp_reg;
            PH_ROLL:  ramp_sel = roll_ramp_reg;
            default:  ramp_sel = fold_ramp_reg;
        endcase
    end

    assign req_ready   = (state_reg == S_IDLE);
    assign cfg_ready   = 1'b1;
    assign req_fire    = req_valid && req_ready;
    assign res_valid   = (state_reg == S_OUT);
    assign res_fire    = res_valid && res_ready;
    assign is_enter    = (req.req_type == REQ_ENTER);
    assign t_x10       = (21'(ticks_reg) << 3) + (21'(ticks_reg) << 1);
    assign r_x7        = (21'(stand_ramp_reg) << 3) - 21'(stand_ramp_reg);
    assign fault       = (cur == PH_STAND) && (t_x10 > r_x7)
                         && (req.upside_down || req.body_height_mm < FAULT_MIN_MM);
    assign enter_stand = !req.upside_down && req.body_height_mm > STAND_MIN_MM
                         && req.body_height_mm < STAND_MAX_MM;
    assign tick_end    = res_fire && (leg_reg == LEG_BITS'(LEG_COUNT - 1));
    assign fold_end    = (cur == PH_FOLD)
                         && (ticks_reg >= TICK_BITS'(fold_ramp_reg) + TICK_BITS'(fold_settle_reg));
    assign roll_end    = (cur == PH_ROLL)
                         && (ticks_reg > TICK_BITS'(roll_ramp_reg) + TICK_BITS'(roll_settle_reg));

    qrss_interp u_interp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == S_START),
        .ini    (start_pose_reg[leg_reg][joint_reg]),
        .fin    (target_pose(cur, leg_reg[0], joint_reg)),
        .t      (ticks_reg),
        .ramp   (ramp_sel),
        .done   (ip_done),
        .result (ip_result)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && !is_enter && !fault)
                    state_next = S_START;
            end
            S_START: state_next = S_WAIT;
            S_WAIT:
            begin
                if (ip_done)
                    state_next = (joint_reg == JNT_KNEE) ? S_OUT : S_START;
            end
            S_OUT:
            begin
                if (res_fire)
                    state_next = tick_end ? S_IDLE : S_START;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_FOLD;
            ticks_reg       <= '0;
            fold_ramp_reg   <= 16'd1000;
            fold_settle_reg <= 16'd1000;
            stand_ramp_reg  <= 16'd500;
            roll_ramp_reg   <= 16'd150;
            roll_settle_reg <= 16'd150;
            leg_reg         <= '0;
            joint_reg       <= JNT_ABD;
            inv_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_FOLD_RAMP:       fold_ramp_reg   <= cfg_data;
                    REG_FOLD_SETTLE:     fold_settle_reg <= cfg_data;
                    REG_STANDUP_RAMP:    stand_ramp_reg  <= cfg_data;
                    REG_ROLLOVER_RAMP:   roll_ramp_reg   <= cfg_data;
                    REG_ROLLOVER_SETTLE: roll_settle_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (req_fire)
            begin
                inv_reg   <= req.upside_down;
                leg_reg   <= '0;
                joint_reg <= JNT_ABD;
                if (is_enter)
                begin
                    phase_reg <= enter_stand ? PH_STAND : PH_FOLD;
                    ticks_reg <= '0;
                end
                else if (fault)
                begin
                    phase_reg <= PH_FOLD;
                    ticks_reg <= '0;
                end
            end
            if (state_reg == S_WAIT && ip_done)
                joint_reg <= (joint_reg == JNT_KNEE) ? JNT_ABD : joint_reg + 2'd1;
            if (res_fire)
                leg_reg <= leg_reg + 1'b1;
            if (tick_end)
            begin
                if (fold_end)
                begin
                    phase_reg <= inv_reg ? PH_ROLL : PH_STAND;
                    ticks_reg <= '0;
                end
                else if (roll_end)
                begin
                    phase_reg <= PH_FOLD;
                    ticks_reg <= '0;
                end
                else
                begin
                    phase_reg <= cur;
                    if (ticks_reg != '1)
                        ticks_reg <= ticks_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire && (is_enter || fault))
        begin
            for (int l = 0; l < LEG_COUNT; l++)
                for (int j = 0; j < 3; j++)
                    start_pose_reg[l][j] <= meas[l % 4][ANGLE_BITS*j +: ANGLE_BITS];
        end
        else if (tick_end && (fold_end || roll_end))
        begin
            for (int l = 0; l < LEG_COUNT; l++)
                for (int j = 0; j < 3; j++)
                    start_pose_reg[l][j] <= target_pose(fold_end ? PH_FOLD : PH_ROLL,
                                                        1'(l % 2), 2'(j));
        end
        if (state_reg == S_WAIT && ip_done)
        begin
            case (joint_reg)
                JNT_ABD: abd_reg  <= ip_result;
                JNT_HIP: hip_reg  <= ip_result;
                default: knee_reg <= ip_result;
            endcase
        end
    end

    assign res.leg_index          = 2'(leg_reg);
    assign res.abduction_setpoint = abd_reg;
    assign res.hip_setpoint       = hip_reg;
    assign res.knee_setpoint      = knee_reg;
    assign res.phase_now          = cur;
    assign res.last               = (leg_reg == LEG_BITS'(LEG_COUNT - 1));

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && res_valid))
        else $error("request taken while result pending");
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ip_done |-> state_reg == S_WAIT)
        else $error("interp done outside wait");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && res.last) |=> req_ready)
        else $error("no return to idle after last leg");

endmodule
